// ===== design/lfp_pkg.sv =====
`default_nettype none

package lfp_pkg;

    localparam int PointsPerFrameDefault = 12;

    localparam logic [7:0] HeaderReset  = 8'd84;
    localparam logic [7:0] VersionReset = 8'd44;
    localparam logic [7:0] CrcPoly      = 8'h4D;

    localparam int CfgIndexW = 8;
    localparam logic [CfgIndexW-1:0] REG_HEADER  = CfgIndexW'(0);
    localparam logic [CfgIndexW-1:0] REG_VERSION = CfgIndexW'(1);

    typedef logic [3:0] step_t;

    // program addresses
    localparam step_t S_HUNT      = 4'd0;
    localparam step_t S_VERSION   = 4'd1;
    localparam step_t S_TEMP_LO   = 4'd2;
    localparam step_t S_TEMP_HI   = 4'd3;
    localparam step_t S_START_LO  = 4'd4;
    localparam step_t S_START_HI  = 4'd5;
    localparam step_t S_DIST_LO   = 4'd6;
    localparam step_t S_DIST_HI   = 4'd7;
    localparam step_t S_INTENSITY = 4'd8;
    localparam step_t S_END_LO    = 4'd9;
    localparam step_t S_END_HI    = 4'd10;
    localparam step_t S_STAMP_LO  = 4'd11;
    localparam step_t S_STAMP_HI  = 4'd12;
    localparam step_t S_CHECK     = 4'd13;
    localparam step_t S_EMIT      = 4'd14;

    typedef enum logic [1:0] {
        CRC_HOLD,
        CRC_UPDATE,
        CRC_CLEAR
    } crc_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC
    } cnt_op_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_TEMP_LO,
        DST_TEMP_HI,
        DST_START_LO,
        DST_START_HI,
        DST_DIST_LO,
        DST_DIST_HI,
        DST_POINT,
        DST_END_LO,
        DST_END_HI,
        DST_STAMP_LO,
        DST_STAMP_HI
    } dest_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_HDR_MISS,
        JC_VER_MISS,
        JC_MORE_POINTS
    } cond_t;

    typedef struct packed {
        logic    take;
        logic    emit;
        logic    check;
        logic    abort;
        crc_op_t crc_op;
        cnt_op_t cnt_op;
        dest_t   dest;
        cond_t   cond;
        step_t   jump_step;
        step_t   next_step;
    } ctrl_word_t;

    typedef struct packed {
        logic hdr_miss;
        logic ver_miss;
        logic more_points;
    } dp_status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CrcPoly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic ctrl_word_t byte_word(input dest_t d, input step_t nxt);
        ctrl_word_t w;
        w = '{take: 1'b1, emit: 1'b0, check: 1'b0, abort: 1'b0,
              crc_op: CRC_UPDATE, cnt_op: CNT_HOLD, dest: d, cond: JC_NONE,
              jump_step: S_HUNT, next_step: nxt};
        return w;
    endfunction

    // control store
    function automatic ctrl_word_t ucode_word(input step_t s);
        ctrl_word_t w;
        w = byte_word(DST_NONE, S_HUNT);
        case (s)
            S_HUNT:
            begin
                w.cnt_op = CNT_CLEAR;
                w.cond   = JC_HDR_MISS;
                w.abort  = 1'b1;
                w.next_step = S_VERSION;
            end
            S_VERSION:
            begin
                w.cond  = JC_VER_MISS;
                w.abort = 1'b1;
                w.next_step = S_TEMP_LO;
            end
            S_TEMP_LO:   w = byte_word(DST_TEMP_LO, S_TEMP_HI);
            S_TEMP_HI:   w = byte_word(DST_TEMP_HI, S_START_LO);
            S_START_LO:  w = byte_word(DST_START_LO, S_START_HI);
            S_START_HI:  w = byte_word(DST_START_HI, S_DIST_LO);
            S_DIST_LO:   w = byte_word(DST_DIST_LO, S_DIST_HI);
            S_DIST_HI:   w = byte_word(DST_DIST_HI, S_INTENSITY);
            S_INTENSITY:
            begin
                w = byte_word(DST_POINT, S_END_LO);
                w.cnt_op    = CNT_INC;
                w.cond      = JC_MORE_POINTS;
                w.jump_step = S_DIST_LO;
            end
            S_END_LO:    w = byte_word(DST_END_LO, S_END_HI);
            S_END_HI:    w = byte_word(DST_END_HI, S_STAMP_LO);
            S_STAMP_LO:  w = byte_word(DST_STAMP_LO, S_STAMP_HI);
            S_STAMP_HI:  w = byte_word(DST_STAMP_HI, S_CHECK);
            S_CHECK:
            begin
                w.crc_op    = CRC_CLEAR;
                w.check     = 1'b1;
                w.next_step = S_EMIT;
            end
            S_EMIT:
            begin
                w.take      = 1'b0;
                w.emit      = 1'b1;
                w.crc_op    = CRC_HOLD;
                w.cnt_op    = CNT_INC;
                w.cond      = JC_MORE_POINTS;
                w.jump_step = S_EMIT;
                w.next_step = S_HUNT;
            end
            default:
            begin
                w.take   = 1'b0;
                w.crc_op = CRC_CLEAR;
                w.cnt_op = CNT_CLEAR;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/lfp_sequencer.sv =====
`default_nettype none

module lfp_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire lfp_pkg::dp_status_t status,
    output lfp_pkg::ctrl_word_t      cw,
    output logic                     taken
);
    import lfp_pkg::*;

    step_t step_reg;
    step_t step_next;

    assign cw = ucode_word(step_reg);

    always_comb
    begin
        case (cw.cond)
            JC_NONE:        taken = 1'b0;
            JC_HDR_MISS:    taken = status.hdr_miss;
            JC_VER_MISS:    taken = status.ver_miss;
            JC_MORE_POINTS: taken = status.more_points;
            default:        taken = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance)
            step_next = taken ? cw.jump_step : cw.next_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_HUNT;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

// ===== design/lfp_datapath.sv =====
`default_nettype none

module lfp_datapath #(
    parameter int POINTS_PER_FRAME = lfp_pkg::PointsPerFrameDefault
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lfp_pkg::ctrl_word_t cw,
    input  wire logic                taken,
    input  wire logic                advance,
    input  wire logic [7:0]          rx_byte,
    input  wire logic [7:0]          header_value,
    input  wire logic [7:0]          version_length_value,
    input  wire logic                out_ready,
    output lfp_pkg::dp_status_t      status,
    output logic                     out_valid,
    output logic [3:0]               point_index,
    output logic [15:0]              distance,
    output logic [7:0]               intensity,
    output logic [15:0]              angle_begin,
    output logic [15:0]              angle_end,
    output logic [15:0]              stamp,
    output logic [15:0]              temperature,
    output logic                     crc_ok,
    output logic [15:0]              good_frames,
    output logic                     last
);
    import lfp_pkg::*;

    localparam int IdxW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(POINTS_PER_FRAME - 1);

    logic [7:0]      crc_reg, crc_next;
    logic [IdxW-1:0] cnt_reg, cnt_next;
    logic [15:0]     good_reg, good_next;
    logic            out_valid_reg, out_valid_next;

    logic [15:0] temp_reg, start_reg, end_reg, stamp_reg;
    logic [7:0]  dist_lo_reg, dist_hi_reg;
    logic        frame_ok_reg;

    logic [23:0] point_mem [POINTS_PER_FRAME];

    logic [3:0]  point_index_reg;
    logic [15:0] distance_reg, start_out_reg, end_out_reg, stamp_out_reg, temp_out_reg;
    logic [7:0]  intensity_reg;
    logic        crc_ok_reg, last_reg;
    logic [15:0] good_out_reg;

    logic fire, load, match_ok, more;

    assign fire     = advance;
    assign load     = fire && cw.emit;
    assign match_ok = (rx_byte == crc_reg);
    assign more     = (cnt_reg != LastIdx);

    assign status.hdr_miss    = (rx_byte != header_value);
    assign status.ver_miss    = (rx_byte != version_length_value);
    assign status.more_points = more;

    always_comb
    begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        good_next = good_reg;
        if (fire)
        begin
            if (taken && cw.abort)
                crc_next = 8'd0;
            else
            begin
                case (cw.crc_op)
                    CRC_HOLD:   crc_next = crc_reg;
                    CRC_UPDATE: crc_next = crc8_update(crc_reg, rx_byte);
                    CRC_CLEAR:  crc_next = 8'd0;
                    default:    crc_next = crc_reg;
                endcase
            end
            case (cw.cnt_op)
                CNT_HOLD:  cnt_next = cnt_reg;
                CNT_CLEAR: cnt_next = '0;
                // wrap after the last point so the next pass starts at zero
                CNT_INC:   cnt_next = more ? cnt_reg + 1'b1 : '0;
                default:   cnt_next = cnt_reg;
            endcase
            if (cw.check && match_ok)
                good_next = good_reg + 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 8'd0;
            cnt_reg       <= '0;
            good_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
            good_reg      <= good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame fields, captured byte by byte
    always_ff @(posedge clk)
    begin
        if (fire && !taken)
        begin
            case (cw.dest)
                DST_TEMP_LO:  temp_reg  <= {8'd0, rx_byte};
                DST_TEMP_HI:  temp_reg  <= {rx_byte, temp_reg[7:0]};
                DST_START_LO: start_reg <= {8'd0, rx_byte};
                DST_START_HI: start_reg <= {rx_byte, start_reg[7:0]};
                DST_DIST_LO:  dist_lo_reg <= rx_byte;
                DST_DIST_HI:  dist_hi_reg <= rx_byte;
                DST_END_LO:   end_reg   <= {8'd0, rx_byte};
                DST_END_HI:   end_reg   <= {rx_byte, end_reg[7:0]};
                DST_STAMP_LO: stamp_reg <= {8'd0, rx_byte};
                DST_STAMP_HI: stamp_reg <= {rx_byte, stamp_reg[7:0]};
                default:      ;
            endcase
        end
        if (fire && cw.check)
            frame_ok_reg <= match_ok;
    end

    // point store: written once per point on its intensity byte
    always_ff @(posedge clk)
    begin
        if (fire && cw.dest == DST_POINT)
            point_mem[cnt_reg] <= {rx_byte, dist_hi_reg, dist_lo_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            point_index_reg <= 4'(cnt_reg);
            distance_reg    <= point_mem[cnt_reg][15:0];
            intensity_reg   <= point_mem[cnt_reg][23:16];
            start_out_reg   <= start_reg;
            end_out_reg     <= end_reg;
            stamp_out_reg   <= stamp_reg;
            temp_out_reg    <= temp_reg;
            crc_ok_reg      <= frame_ok_reg;
            good_out_reg    <= good_reg;
            last_reg        <= !more;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_index = point_index_reg;
    assign distance    = distance_reg;
    assign intensity   = intensity_reg;
    assign angle_begin = start_out_reg;
    assign angle_end   = end_out_reg;
    assign stamp       = stamp_out_reg;
    assign temperature = temp_out_reg;
    assign crc_ok      = crc_ok_reg;
    assign good_frames = good_out_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== design/lidar_frame_parser.sv =====
// Byte-serial lidar frame parser. Each accepted input word is one received
// byte of a frame of 6 + 3*POINTS_PER_FRAME + 5 bytes (47 for 12 points):
// header, version/length, temperature, start angle, the points (distance,
// intensity), end angle, timestamp and a CRC-8 (poly 0x4D, init 0). A header
// or version byte that does not match the programmed value sends the parser
// back to header hunt. After the CRC byte the block emits POINTS_PER_FRAME
// point words through an output register, one per cycle while that register
// is free, and takes no input during that burst; the microcode emit step,
// which reads one point store entry per emitted word, sets this.
// Registers: index 0 header byte (reset 84), index 1 version byte (reset 44);
// write them only while the parser is idle.
`default_nettype none

module lidar_frame_parser #(
    parameter int POINTS_PER_FRAME = lfp_pkg::PointsPerFrameDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lfp_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   rx_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [3:0]                        point_index,
    output logic [15:0]                       distance,
    output logic [7:0]                        intensity,
    output logic [15:0]                       angle_begin,
    output logic [15:0]                       angle_end,
    output logic [15:0]                       stamp,
    output logic [15:0]                       temperature,
    output logic                              crc_ok,
    output logic [15:0]                       good_frames,
    output logic                              last
);
    import lfp_pkg::*;

    ctrl_word_t cw;
    dp_status_t status;
    logic       taken;
    logic       advance;
    logic [7:0] header_reg, version_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HeaderReset;
            version_reg <= VersionReset;
        end
        else if (cfg_valid)
        begin
            // drop writes to unknown indexes
            if (cfg_index == REG_HEADER)
                header_reg <= cfg_data;
            else if (cfg_index == REG_VERSION)
                version_reg <= cfg_data;
        end
    end

    assign in_ready = cw.take;

    // a byte step advances on an accepted word, an emit step when the
    // output register is free
    always_comb
    begin
        if (cw.take)
            advance = in_valid;
        else if (cw.emit)
            advance = !out_valid || out_ready;
        else
            advance = 1'b1;
    end

    lfp_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .status  (status),
        .cw      (cw),
        .taken   (taken)
    );

    lfp_datapath #(
        .POINTS_PER_FRAME (POINTS_PER_FRAME)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cw                   (cw),
        .taken                (taken),
        .advance              (advance),
        .rx_byte              (rx_byte),
        .header_value         (header_reg),
        .version_length_value (version_reg),
        .out_ready            (out_ready),
        .status               (status),
        .out_valid            (out_valid),
        .point_index          (point_index),
        .distance             (distance),
        .intensity            (intensity),
        .angle_begin          (angle_begin),
        .angle_end            (angle_end),
        .stamp                (stamp),
        .temperature          (temperature),
        .crc_ok               (crc_ok),
        .good_frames          (good_frames),
        .last                 (last)
    );

endmodule

`default_nettype wire

// ===== dv/lidar_frame_parser_test.sv =====
`default_nettype none

module lidar_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS            = lfp_pkg::PointsPerFrameDefault;
    localparam int FIRST_POINT_PHASE = 6;
    localparam int END_LO_PHASE      = FIRST_POINT_PHASE + 3 * POINTS;
    localparam int CRC_PHASE         = END_LO_PHASE + 4;
    localparam int FRAME_BYTES       = CRC_PHASE + 1;
    localparam int DRAIN_CYCLES      = 2 * POINTS + 16;
    localparam int BYTES_PER_PHASE   = 50;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int REPORT_LIMIT      = 10;

    typedef logic [lfp_pkg::CfgIndexW-1:0] cfg_index_t;

    typedef struct packed {
        logic [3:0]  point_index;
        logic [15:0] distance;
        logic [7:0]  intensity;
        logic [15:0] angle_begin;
        logic [15:0] angle_end;
        logic [15:0] stamp;
        logic [15:0] temperature;
        logic        crc_ok;
        logic [15:0] good_frames;
        logic        last;
    } point_word_t;

    class point_tracker;
        logic [7:0]  header_val;
        logic [7:0]  version_val;
        int          phase;
        logic [7:0]  crc;
        int          pt_cnt;
        logic [15:0] dist_mem [POINTS];
        logic [7:0]  inten_mem [POINTS];
        logic [15:0] temp_word;
        logic [15:0] start_word;
        logic [15:0] end_word;
        logic [15:0] stamp_word;
        logic [15:0] good_cnt;
        point_word_t pending_points [$];
        int          mismatches;
        int          points_checked;
        int          frames_closed;
        int          frames_good;

        function new();
            header_val  = lfp_pkg::HeaderReset;
            version_val = lfp_pkg::VersionReset;
            phase       = 0;
            crc         = 8'h00;
            pt_cnt      = 0;
            temp_word   = '0;
            start_word  = '0;
            end_word    = '0;
            stamp_word  = '0;
            good_cnt    = '0;
            mismatches  = 0;
            points_checked = 0;
            frames_closed  = 0;
            frames_good    = 0;
            foreach (dist_mem[k])
            begin
                dist_mem[k]  = '0;
                inten_mem[k] = '0;
            end
        endfunction

        static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = c ^ b;
            repeat (8)
            begin
                fb = r[7];
                r  = r << 1;
                if (fb)
                    r ^= lfp_pkg::CrcPoly;
            end
            return r;
        endfunction

        static function string describe(point_word_t p);
            return $sformatf({"idx=%0d dist=%h int=%h angle_begin=%h angle_end=%h",
                              " stamp=%h temp=%h crc_ok=%b good=%0d last=%b"},
                             p.point_index, p.distance, p.intensity, p.angle_begin,
                             p.angle_end, p.stamp, p.temperature, p.crc_ok,
                             p.good_frames, p.last);
        endfunction

        function void set_register(logic [lfp_pkg::CfgIndexW-1:0] idx, logic [7:0] d);
            if (idx == lfp_pkg::REG_HEADER)
                header_val = d;
            else if (idx == lfp_pkg::REG_VERSION)
                version_val = d;
        endfunction

        function bit hunting();
            return phase == 0;
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction

        function void absorb_byte(logic [7:0] b);
            int          sub;
            point_word_t p;
            if (phase == 0)
            begin
                if (b == header_val)
                begin
                    crc    = crc8_next(8'h00, b);
                    pt_cnt = 0;
                    phase  = 1;
                end
                else
                    crc = 8'h00;
            end
            else if (phase == 1)
            begin
                // a failed version byte goes back to hunting without a second look
                if (b == version_val)
                begin
                    crc   = crc8_next(crc, b);
                    phase = 2;
                end
                else
                begin
                    crc   = 8'h00;
                    phase = 0;
                end
            end
            else if (phase < CRC_PHASE)
            begin
                crc = crc8_next(crc, b);
                if (phase == 2)
                    temp_word = {8'h00, b};
                else if (phase == 3)
                    temp_word[15:8] = b;
                else if (phase == 4)
                    start_word = {8'h00, b};
                else if (phase == 5)
                    start_word[15:8] = b;
                else if (phase < END_LO_PHASE)
                begin
                    sub = (phase - FIRST_POINT_PHASE) % 3;
                    case (sub)
                        0:       dist_mem[pt_cnt] = {8'h00, b};
                        1:       dist_mem[pt_cnt][15:8] = b;
                        default: inten_mem[pt_cnt] = b;
                    endcase
                    if (sub == 2)
                        pt_cnt++;
                end
                else if (phase == END_LO_PHASE)
                    end_word = {8'h00, b};
                else if (phase == END_LO_PHASE + 1)
                    end_word[15:8] = b;
                else if (phase == END_LO_PHASE + 2)
                    stamp_word = {8'h00, b};
                else
                    stamp_word[15:8] = b;
                phase++;
            end
            else
            begin
                p.crc_ok = (b == crc);
                if (p.crc_ok)
                begin
                    good_cnt++;
                    frames_good++;
                end
                frames_closed++;
                for (int k = 0; k < POINTS; k++)
                begin
                    p.point_index = 4'(k);
                    p.distance    = dist_mem[k];
                    p.intensity   = inten_mem[k];
                    p.angle_begin = start_word;
                    p.angle_end   = end_word;
                    p.stamp       = stamp_word;
                    p.temperature = temp_word;
                    p.good_frames = good_cnt;
                    p.last        = (k == POINTS - 1);
                    pending_points.push_back(p);
                end
                crc    = 8'h00;
                pt_cnt = 0;
                phase  = 0;
            end
        endfunction

        function void match_point(point_word_t got);
            point_word_t want;
            string       diffs;
            points_checked++;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected point word: %s", describe(got));
                return;
            end
            want  = pending_points.pop_front();
            diffs = "";
            if (got.point_index !== want.point_index) diffs = {diffs, " point_index"};
            if (got.distance !== want.distance)       diffs = {diffs, " distance"};
            if (got.intensity !== want.intensity)     diffs = {diffs, " intensity"};
            if (got.angle_begin !== want.angle_begin) diffs = {diffs, " angle_begin"};
            if (got.angle_end !== want.angle_end)     diffs = {diffs, " angle_end"};
            if (got.stamp !== want.stamp)             diffs = {diffs, " stamp"};
            if (got.temperature !== want.temperature) diffs = {diffs, " temperature"};
            if (got.crc_ok !== want.crc_ok)           diffs = {diffs, " crc_ok"};
            if (got.good_frames !== want.good_frames) diffs = {diffs, " good_frames"};
            if (got.last !== want.last)               diffs = {diffs, " last"};
            if (diffs != "")
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("point word mismatch on%s", diffs);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [lfp_pkg::CfgIndexW-1:0]    cfg_index = '0;
    logic [7:0]                       cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [7:0]                       rx_byte = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [3:0]                       point_index;
    logic [15:0]                      distance;
    logic [7:0]                       intensity;
    logic [15:0]                      angle_begin;
    logic [15:0]                      angle_end;
    logic [15:0]                      stamp;
    logic [15:0]                      temperature;
    logic                             crc_ok;
    logic [15:0]                      good_frames;
    logic                             last;

    point_tracker tracker = new();
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           bytes_sent = 0;
    int           cycles = 0;
    logic [7:0]   cur_header = lfp_pkg::HeaderReset;
    logic [7:0]   cur_version = lfp_pkg::VersionReset;

    lidar_frame_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_index (point_index),
        .distance    (distance),
        .intensity   (intensity),
        .angle_begin (angle_begin),
        .angle_end   (angle_end),
        .stamp       (stamp),
        .temperature (temperature),
        .crc_ok      (crc_ok),
        .good_frames (good_frames),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d point words outstanding",
                     cycles, tracker.outstanding());
            $display("lidar_frame_parser verification failed");
            $finish;
        end
    end

    // sample the output word, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_point('{point_index, distance, intensity, angle_begin, angle_end,
                                  stamp, temperature, crc_ok, good_frames, last});
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.absorb_byte(b);
        bytes_sent++;
    endtask

    // fill < 0 gives random content, otherwise every content byte is fill
    task automatic send_frame(input int fill, input bit bad_crc);
        logic [7:0] frame [FRAME_BYTES];
        logic [7:0] c;
        frame[0] = cur_header;
        frame[1] = cur_version;
        for (int i = 2; i < CRC_PHASE; i++)
            frame[i] = (fill < 0) ? pick_byte() : 8'(fill);
        c = 8'h00;
        for (int i = 0; i < CRC_PHASE; i++)
            c = point_tracker::crc8_next(c, frame[i]);
        if (bad_crc)
            c ^= 8'($urandom_range(1, 255));
        frame[CRC_PHASE] = c;
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(frame[i]);
    endtask

    // drop valid, wait out every point word, then let the parser go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] hdr, input logic [7:0] ver);
        logic [lfp_pkg::CfgIndexW-1:0] idx [3];
        logic [7:0]                    val [3];
        idx[0] = lfp_pkg::REG_HEADER;
        val[0] = hdr;
        idx[1] = lfp_pkg::REG_VERSION;
        val[1] = ver;
        // out-of-range index must leave both registers alone
        idx[2] = cfg_index_t'(lfp_pkg::REG_VERSION + 1 + $urandom_range(0, 253));
        val[2] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.set_register(idx[i], val[i]);
        end
        cfg_valid   <= 1'b0;
        cur_header  = hdr;
        cur_version = ver;
    endtask

    task automatic run_phase(input int sp, input int rp, input logic [7:0] hdr,
                             input logic [7:0] ver);
        int counted;
        int pick;
        int n;
        settle();
        program_regs(hdr, ver);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        counted = 0;
        while (counted < BYTES_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_frame(-1, $urandom_range(0, 3) == 0);
                counted += FRAME_BYTES;
            end
            else if (pick < 80)
            begin
                send_byte(cur_header);
                if ($urandom_range(0, 1))
                begin
                    send_byte(cur_version ^ 8'($urandom_range(1, 255)));
                    counted += 2;
                end
                else
                begin
                    // truncated frame: the next one gets swallowed as data
                    send_byte(cur_version);
                    n = $urandom_range(1, CRC_PHASE - 3);
                    repeat (n) send_byte(pick_byte());
                    counted += n + 2;
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                counted += n;
            end
        end
        // finish any open frame so the parser is back in header hunt
        while (!tracker.hunting())
            send_byte(pick_byte());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values, pacing of the first phase
        send_idle_pct  = 13;
        recv_stall_pct = 59;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_header ^ 8'h01);
        send_byte(cur_header);
        send_byte(cur_header);
        send_byte(cur_version);
        send_frame(8'hFF, 1'b0);
        send_frame(8'h00, 1'b1);

        run_phase(13, 59, 8'h00, 8'hFF);
        run_phase(59, 13, 8'hFF, 8'h00);
        run_phase(0, 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        settle();

        $display("Sent %0d bytes under reset, extreme and random header/version settings",
                 bytes_sent);
        $display("Closed %0d frames (%0d with good CRC), checked %0d point words, %0d bad",
                 tracker.frames_closed, tracker.frames_good, tracker.points_checked,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("lidar_frame_parser verification clean");
        else
            $display("lidar_frame_parser verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/lfp_pkg.sv
design/lfp_sequencer.sv
design/lfp_datapath.sv
design/lidar_frame_parser.sv
dv/lidar_frame_parser_test.sv
